[rtl/sb64_pkg.sv]
// ----------------------------------------------------------------------------
// sb64_pkg
// shared types, codes and the character lookup of the strict base64 decoder
// ----------------------------------------------------------------------------
package sb64_pkg;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_PAD  = 3'd1,
		ST_CHAR = 3'd2,
		ST_BITS = 3'd3,
		ST_LEN  = 3'd4
	} status_t;

	localparam logic [7:0] PAD_CHAR   = 8'h3d;
	localparam logic [7:0] PLUS_CHAR  = 8'h2b;
	localparam logic [7:0] SLASH_CHAR = 8'h2f;
	localparam logic [5:0] OFS_LOWER  = 6'd26;
	localparam logic [5:0] OFS_DIGIT  = 6'd52;
	localparam logic [5:0] VAL_PLUS   = 6'd62;
	localparam logic [5:0] VAL_SLASH  = 6'd63;
	localparam logic [5:0] MASK_LOW4  = 6'h0f;
	localparam logic [5:0] MASK_LOW2  = 6'h03;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	// group result: one to three bytes, last_idx is count minus one
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		status_t         status;
		logic            done;
	} bundle_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		logic [7:0] t;
		r = '{ok: 1'b1, val: '0};
		t = '0;
		if (c inside {[8'h41:8'h5a]}) begin
			t = c - 8'h41;
			r.val = t[5:0];
		end else if (c inside {[8'h61:8'h7a]}) begin
			t = c - 8'h61;
			r.val = t[5:0] + OFS_LOWER;
		end else if (c inside {[8'h30:8'h39]}) begin
			t = c - 8'h30;
			r.val = t[5:0] + OFS_DIGIT;
		end else if (c == PLUS_CHAR) begin
			r.val = VAL_PLUS;
		end else if (c == SLASH_CHAR) begin
			r.val = VAL_SLASH;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/sb64_group.sv]
// ----------------------------------------------------------------------------
// sb64_group
// gathers characters into groups of four, checks each group and builds the
// result bundle for the output queue
// ----------------------------------------------------------------------------
module sb64_group (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        symbol,
	input  logic              end_of_message,
	output logic              push,
	output sb64_pkg::bundle_t bundle
);

	logic [1:0]       pos_q;
	logic [2:0][5:0]  held_q;
	logic             third_pad_q;
	logic             bad_q;
	sb64_pkg::status_t err_q;

	logic [1:0]       pos_d;
	logic [2:0][5:0]  held_d;
	logic             third_pad_d;
	logic             bad_d;
	sb64_pkg::status_t err_d;

	sb64_pkg::sextet_t sx;
	sb64_pkg::status_t chk;
	sb64_pkg::status_t eff;
	logic              pad3;
	logic              bad4;
	logic [5:0]        d4;
	logic [5:0]        a, b, c;

	assign sx = sb64_pkg::sextet_of(symbol);
	assign a  = held_q[0];
	assign b  = held_q[1];
	assign c  = held_q[2];
	assign pad3 = (symbol == sb64_pkg::PAD_CHAR);
	assign bad4 = bad_q | (!pad3 && !sx.ok);
	assign d4   = (!pad3 && sx.ok) ? sx.val : 6'd0;

	always_comb begin
		chk = sb64_pkg::ST_OK;
		if (!end_of_message && (third_pad_q || pad3)) begin
			chk = sb64_pkg::ST_PAD;
		end else if (third_pad_q && !pad3) begin
			chk = sb64_pkg::ST_PAD;
		end else if (bad4) begin
			chk = sb64_pkg::ST_CHAR;
		end else if ((third_pad_q && ((b & sb64_pkg::MASK_LOW4) != 6'd0)) ||
		             (pad3 && !third_pad_q && ((c & sb64_pkg::MASK_LOW2) != 6'd0))) begin
			chk = sb64_pkg::ST_BITS;
		end
		eff = (err_q != sb64_pkg::ST_OK) ? err_q : chk;
	end

	always_comb begin
		pos_d       = pos_q;
		held_d      = held_q;
		third_pad_d = third_pad_q;
		bad_d       = bad_q;
		err_d       = err_q;
		push        = 1'b0;
		bundle      = '{bytes: '0, last_idx: 2'd0, status: sb64_pkg::ST_OK, done: 1'b0};
		if (take) begin
			if (pos_q != 2'd3) begin
				if (pos_q == 2'd2 && pad3) begin
					third_pad_d = 1'b1;
					held_d[pos_q] = 6'd0;
				end else if (!sx.ok) begin
					bad_d = 1'b1;
					held_d[pos_q] = 6'd0;
				end else begin
					held_d[pos_q] = sx.val;
				end
				if (end_of_message) begin
					push          = 1'b1;
					bundle.status = sb64_pkg::ST_LEN;
					bundle.done   = 1'b1;
					pos_d         = 2'd0;
					held_d        = '0;
					third_pad_d   = 1'b0;
					bad_d         = 1'b0;
					err_d         = sb64_pkg::ST_OK;
				end else begin
					pos_d = pos_q + 2'd1;
				end
			end else begin
				pos_d       = 2'd0;
				held_d      = '0;
				third_pad_d = 1'b0;
				bad_d       = 1'b0;
				err_d       = eff;
				if (eff != sb64_pkg::ST_OK) begin
					if (end_of_message) begin
						push          = 1'b1;
						bundle.status = eff;
						bundle.done   = 1'b1;
					end
				end else begin
					push = 1'b1;
					bundle.bytes[0] = {a, b[5:4]};
					bundle.bytes[1] = {b[3:0], c[5:2]};
					bundle.bytes[2] = {c[1:0], d4};
					bundle.last_idx = 2'd2 - {1'b0, third_pad_q} - {1'b0, pad3};
					bundle.done     = end_of_message;
				end
				if (end_of_message) begin
					err_d = sb64_pkg::ST_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			held_q      <= '0;
			third_pad_q <= 1'b0;
			bad_q       <= 1'b0;
			err_q       <= sb64_pkg::ST_OK;
		end else begin
			pos_q       <= pos_d;
			held_q      <= held_d;
			third_pad_q <= third_pad_d;
			bad_q       <= bad_d;
			err_q       <= err_d;
		end
	end

endmodule

[rtl/sb64_outq.sv]
// ----------------------------------------------------------------------------
// sb64_outq
// two-entry queue of group bundles, serialized into one result per transfer
// ----------------------------------------------------------------------------
module sb64_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sb64_pkg::bundle_t bundle,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        data_byte,
	output logic [2:0]        status,
	output logic              run_last,
	output logic              message_done
);

	sb64_pkg::bundle_t ent_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;
	logic [1:0]        idx_q;
	sb64_pkg::bundle_t head;
	logic              xfer;
	logic              pop;
	logic              do_push;

	assign head         = ent_q[rd_q];
	assign full         = (cnt_q == 2'd2);
	assign out_valid    = (cnt_q != 2'd0);
	assign data_byte    = (idx_q == 2'd3) ? 8'd0 : head.bytes[idx_q];
	assign status       = head.status;
	assign run_last     = (idx_q == head.last_idx);
	assign message_done = head.done && run_last;
	assign xfer         = out_valid && !out_stall;
	assign pop          = xfer && run_last;
	assign do_push      = push && !full;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q  <= !rd_q;
				idx_q <= 2'd0;
			end else if (xfer) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("bundle pushed into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q <= head.last_idx) else $error("byte index past bundle end");

	a_mid_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !run_last) |=> out_valid) else $error("bundle lost mid transfer");

endmodule

[rtl/strict_base64_decoder_top.sv]
// ----------------------------------------------------------------------------
// strict_base64_decoder_top
// strict base64 decoder: characters in, checked decoded bytes or status out
// ----------------------------------------------------------------------------
// a character is registered at the input stage, then its group's bundle is registered into the queue
// one character per cycle while in_stall is low, results leave one per cycle while out_stall is low
// a group's bundle waits in a two-entry queue while its bytes drain
// the input stalls only while both queue entries are held
// reset: arst_n clears group state, latched error and queue; no sweep needed
// ----------------------------------------------------------------------------
module strict_base64_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic [2:0] status,
	output logic       run_last,
	output logic       message_done
);

	logic              valid_s1;
	logic [7:0]        symbol_s1;
	logic              eom_s1;
	logic              full;
	logic              take;
	logic              push;
	sb64_pkg::bundle_t bundle;

	assign take     = valid_s1 && !full;
	assign in_stall = valid_s1 && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			symbol_s1 <= symbol;
			eom_s1    <= end_of_message;
		end
	end

	sb64_group u_group (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.symbol         (symbol_s1),
		.end_of_message (eom_s1),
		.push           (push),
		.bundle         (bundle)
	);

	sb64_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.bundle       (bundle),
		.full         (full),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.status       (status),
		.run_last     (run_last),
		.message_done (message_done)
	);

endmodule

[sim/strict_base64_decoder_top_test.sv]
// ----------------------------------------------------------------------------
// strict_base64_decoder_top_test
// self-checking bench for the strict base64 decoder: a directed set of short
// messages covering each error code is followed by random messages, most of
// them well formed and some damaged. Both sides idle at random, and every
// output transfer is compared against a scoreboard that decodes the same
// characters on its own.
// ----------------------------------------------------------------------------
module strict_base64_decoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	class decode_scoreboard;
		typedef struct {
			logic [7:0]        data;
			sb64_pkg::status_t status;
			logic              last;
			logic              done;
		} byte_result_t;

		byte_result_t      expected_q[$];
		int                fail_count;
		logic [1:0]        slot;
		logic [5:0]        sextets[3];
		bit                third_pad;
		bit                bad_char;
		sb64_pkg::status_t first_error;

		function new();
			fail_count = 0;
			restart();
		endfunction

		function void clear_group();
			slot = 2'd0;
			sextets[0] = '0;
			sextets[1] = '0;
			sextets[2] = '0;
			third_pad = 1'b0;
			bad_char = 1'b0;
		endfunction

		function void restart();
			clear_group();
			first_error = sb64_pkg::ST_OK;
		endfunction

		function void decode_char(input logic [7:0] c, output bit ok, output logic [5:0] v);
			logic [7:0] t;
			ok = 1'b1;
			v = '0;
			if (c >= 8'h41 && c <= 8'h5a) begin
				t = c - 8'h41;
				v = t[5:0];
			end else if (c >= 8'h61 && c <= 8'h7a) begin
				t = c - 8'h61;
				v = t[5:0] + 6'd26;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				t = c - 8'h30;
				v = t[5:0] + 6'd52;
			end else if (c == 8'h2b) begin
				v = 6'd62;
			end else if (c == 8'h2f) begin
				v = 6'd63;
			end else begin
				ok = 1'b0;
			end
		endfunction

		function void push_result(logic [7:0] d, sb64_pkg::status_t s, logic l, logic m);
			byte_result_t r;
			r.data = d;
			r.status = s;
			r.last = l;
			r.done = m;
			expected_q = {expected_q, r};
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task note_symbol(input logic [7:0] sym, input logic eom);
			bit                ok;
			bit                pad3;
			bit                pad4;
			bit                bad;
			logic [5:0]        v;
			logic [5:0]        a;
			logic [5:0]        b;
			logic [5:0]        c;
			logic [5:0]        d;
			sb64_pkg::status_t err;
			logic [7:0]        bytes[3];
			int                count;
			if (slot != 2'd3) begin
				if (slot == 2'd2 && sym == sb64_pkg::PAD_CHAR) begin
					third_pad = 1'b1;
					sextets[2] = '0;
				end else begin
					decode_char(sym, ok, v);
					if (!ok) begin
						bad_char = 1'b1;
						sextets[slot] = '0;
					end else begin
						sextets[slot] = v;
					end
				end
				if (eom) begin
					push_result(8'h00, sb64_pkg::ST_LEN, 1'b1, 1'b1);
					restart();
				end else begin
					slot = slot + 2'd1;
				end
				return;
			end
			// group complete
			pad3 = third_pad;
			pad4 = (sym == sb64_pkg::PAD_CHAR);
			a = sextets[0];
			b = sextets[1];
			c = sextets[2];
			d = '0;
			bad = bad_char;
			if (!pad4) begin
				decode_char(sym, ok, v);
				if (!ok)
					bad = 1'b1;
				else
					d = v;
			end
			clear_group();
			if (first_error == sb64_pkg::ST_OK) begin
				if (!eom && (pad3 || pad4))
					err = sb64_pkg::ST_PAD;
				else if (pad3 && !pad4)
					err = sb64_pkg::ST_PAD;
				else if (bad)
					err = sb64_pkg::ST_CHAR;
				else if ((pad3 && b[3:0] != 4'd0) || (pad4 && !pad3 && c[1:0] != 2'd0))
					err = sb64_pkg::ST_BITS;
				else
					err = sb64_pkg::ST_OK;
				first_error = err;
			end
			if (first_error != sb64_pkg::ST_OK) begin
				if (eom) begin
					push_result(8'h00, first_error, 1'b1, 1'b1);
					restart();
				end
				return;
			end
			bytes[0] = {a, b[5:4]};
			bytes[1] = {b[3:0], c[5:2]};
			bytes[2] = {c[1:0], d};
			count = 1 + (pad3 ? 0 : 1) + (pad4 ? 0 : 1);
			for (int i = 0; i < count; i++)
				push_result(bytes[i], sb64_pkg::ST_OK, i == count - 1,
					(i == count - 1) && eom);
			if (eom)
				restart();
		endtask

		task report(input string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			fail_count++;
		endtask

		task check_result(input logic [7:0] data, input logic [2:0] st, input logic last,
				input logic done);
			byte_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result data_byte %02h status %0d", data, st));
				return;
			end
			want = expected_q.pop_front();
			if (data !== want.data)
				report($sformatf("data_byte %02h, expected %02h", data, want.data));
			if (st !== want.status)
				report($sformatf("status %0d, expected %0d", st, want.status));
			if (last !== want.last)
				report($sformatf("run_last %b, expected %b", last, want.last));
			if (done !== want.done)
				report($sformatf("message_done %b, expected %b", done, want.done));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] symbol = 8'h00;
	logic       end_of_message = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] data_byte;
	logic [2:0] status;
	logic       run_last;
	logic       message_done;

	decode_scoreboard sb = new();
	bit  steady = 1'b0;
	int  stall_hold = 0;
	int  stall_pick;
	int  random_items = 0;

	strict_base64_decoder_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.symbol        (symbol),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.status        (status),
		.run_last      (run_last),
		.message_done  (message_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] char_of(input logic [5:0] v);
		if (v < 6'd26)
			return 8'h41 + {2'b00, v};
		if (v < 6'd52)
			return 8'h61 + {2'b00, v - 6'd26};
		if (v < 6'd62)
			return 8'h30 + {2'b00, v - 6'd52};
		if (v == 6'd62)
			return 8'h2b;
		return 8'h2f;
	endfunction

	// output stall pattern
	always @(posedge clk) begin
		if (steady) begin
			out_stall <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_hold <= $urandom_range(0, 6);
		end else begin
			stall_pick = idle_len();
			if (stall_pick != 0) begin
				out_stall <= 1'b1;
				stall_hold <= stall_pick - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(data_byte, status, run_last, message_done);
	end

	task automatic send_char(input logic [7:0] sym, input logic eom);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= sym;
		end_of_message <= eom;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_symbol(sym, eom);
		random_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_random_message();
		logic [7:0] msg[$];
		logic [5:0] v;
		logic [3:0] hi;
		int         groups;
		int         n;
		int         kind;
		int         k;
		groups = $urandom_range(1, 4);
		for (int i = 0; i < 4 * groups; i++)
			msg = {msg, char_of(6'($urandom_range(0, 63)))};
		n = msg.size();
		case ($urandom_range(0, 2))
			1: begin
				hi = 4'($urandom_range(0, 15));
				v = {hi, 2'b00};
				msg[n - 2] = char_of(v);
				msg[n - 1] = sb64_pkg::PAD_CHAR;
			end
			2: begin
				v = {2'($urandom_range(0, 3)), 4'b0000};
				msg[n - 3] = char_of(v);
				msg[n - 2] = sb64_pkg::PAD_CHAR;
				msg[n - 1] = sb64_pkg::PAD_CHAR;
			end
			default: begin
			end
		endcase
		// damaged messages
		if ($urandom_range(0, 99) < 35) begin
			kind = $urandom_range(0, 4);
			k = $urandom_range(0, msg.size() - 1);
			case (kind)
				0: msg[k] = 8'($urandom_range(0, 255));
				1: msg[k] = sb64_pkg::PAD_CHAR;
				2: begin
					repeat ($urandom_range(1, 3))
						if (msg.size() > 1)
							void'(msg.pop_back());
				end
				3: msg[k] = char_of(6'($urandom_range(0, 63)));
				default: begin
					repeat ($urandom_range(1, 5))
						msg = {msg, 8'($urandom_range(0, 255))};
				end
			endcase
		end
		steady <= ($urandom_range(0, 3) == 0);
		for (int i = 0; i < msg.size(); i++)
			send_char(msg[i], i == msg.size() - 1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_text("/+9aZm8=");
		send_text("Zh==");
		send_text("Zg==AAAA");
		send_text("Zm=A");
		send_char("A", 1'b0);
		send_char(sb64_pkg::PAD_CHAR, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b1);
		send_char("z", 1'b1);
		while (random_items < 180)
			send_random_message();
		in_valid <= 1'b0;
		end_of_message <= 1'b0;
		steady <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fail_count == 0)
			$display("** strict_base64_decoder_top: PASSED **");
		else
			$display("** strict_base64_decoder_top: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout, %0d transfers still expected", sb.pending());
		$display("** strict_base64_decoder_top: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
rtl/sb64_pkg.sv
rtl/sb64_group.sv
rtl/sb64_outq.sv
rtl/strict_base64_decoder_top.sv
sim/strict_base64_decoder_top_test.sv
